/* rtl/core/pcs_pkg.sv */
package pcs_pkg;

  localparam int SR_W   = 17;
  localparam int CMD_W  = 2;
  localparam int LEN_W  = 16;
  localparam int BYTE_W = 8;
  localparam int SMP_W  = 16;
  localparam int TONE_W = 15;
  localparam int SEG_W  = 10;
  localparam int PH_W   = 10;
  localparam int PROD_W = PH_W + TONE_W;
  localparam int DIV_W  = PROD_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int SEG_PRE_SH  = 2;
  localparam int SEG_RECIP_W = 16;
  localparam int SEG_PROD_W  = SR_W - SEG_PRE_SH + SEG_RECIP_W;
  localparam int SEG_SHIFT   = 21;

  localparam logic [7:0]        SEG_RATE     = 8'd140;
  localparam logic [SEG_RECIP_W-1:0] SEG_RECIP = 16'd59919;
  localparam logic [20:0]       PIT_CLOCK    = 21'd1193180;
  localparam logic [5:0]        RELOAD_SCALE = 6'd60;
  localparam logic [SR_W-1:0]   SR_RESET     = 17'd44100;
  localparam logic [SMP_W-1:0]  SQUARE_POS   = 16'h2000;
  localparam logic [SMP_W-1:0]  SQUARE_NEG   = 16'hE000;
  localparam logic [BYTE_W-1:0] BYTE_FRESH   = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

endpackage

/* rtl/core/pcs_ifs.sv */
interface pcs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [pcs_pkg::SR_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pcs_in_if;
  logic                               valid;
  logic                               ready;
  logic        [pcs_pkg::CMD_W-1:0]   command;
  logic        [pcs_pkg::LEN_W-1:0]   start_length;
  logic        [pcs_pkg::BYTE_W-1:0]  sound_byte;
  logic signed [pcs_pkg::SMP_W-1:0]   left_in;
  logic signed [pcs_pkg::SMP_W-1:0]   right_in;

  modport source (output valid, output command, output start_length, output sound_byte,
                  output left_in, output right_in, input ready);
  modport sink   (input valid, input command, input start_length, input sound_byte,
                  input left_in, input right_in, output ready);
endinterface

interface pcs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pcs_pkg::SMP_W-1:0]  left_out;
  logic signed [pcs_pkg::SMP_W-1:0]  right_out;
  logic                              byte_taken;
  logic                              sound_done;
  logic                              playing;

  modport source (output valid, output left_out, output right_out, output byte_taken,
                  output sound_done, output playing, input ready);
  modport sink   (input valid, input left_out, input right_out, input byte_taken,
                  input sound_done, input playing, output ready);
endinterface

/* rtl/core/pc_speaker_square_wave_synth.sv */
// Start, stop and command 3 go straight to the output register; a tick may first run a
// tone division when a segment starts and a phase division, both on the shared 26-step
// radix-2 divider. One item at a time: the next is taken only after the result enters the
// output register, which waits while that register holds a result not yet taken.
// Reset (rst_n, synchronous, active low) stops the sound, clears all tone state and
// sets the sample rate to 44100.
module pc_speaker_square_wave_synth (
  input  logic             clk,
  input  logic             rst_n,
  pcs_cfg_if.sink          cfg_ch,
  pcs_in_if.sink           in_ch,
  pcs_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEG_END,
    S_TONE_DIV,
    S_TONE_END,
    S_PHASE,
    S_PH_DIV,
    S_PH_END,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [pcs_pkg::SR_W-1:0]      sr_r, sr_nxt;
  logic                          active_r, active_nxt;
  logic [pcs_pkg::LEN_W-1:0]     bytes_left_r, bytes_left_nxt;
  logic [pcs_pkg::BYTE_W-1:0]    prev_byte_r, prev_byte_nxt;
  logic [pcs_pkg::TONE_W-1:0]    tone_r, tone_nxt;
  logic [pcs_pkg::SEG_W-1:0]     seg_left_r, seg_left_nxt;
  logic [pcs_pkg::PH_W-1:0]      phase_r, phase_nxt;

  logic [pcs_pkg::SR_W-1:0]      div_rem_r, div_rem_nxt;
  logic [pcs_pkg::DIV_W-1:0]     div_dvd_r, div_dvd_nxt;
  logic [pcs_pkg::SR_W-1:0]      div_dsr_r, div_dsr_nxt;
  logic [pcs_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic [pcs_pkg::BYTE_W-1:0]    sb_r, sb_nxt;
  logic [pcs_pkg::SMP_W-1:0]     left_r, left_nxt;
  logic [pcs_pkg::SMP_W-1:0]     right_r, right_nxt;
  logic [pcs_pkg::SMP_W-1:0]     add_r, add_nxt;
  logic                          taken_r, taken_nxt;
  logic                          done_r, done_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [pcs_pkg::SMP_W-1:0]     out_left_r, out_left_nxt;
  logic [pcs_pkg::SMP_W-1:0]     out_right_r, out_right_nxt;
  logic                          out_taken_r, out_taken_nxt;
  logic                          out_done_r, out_done_nxt;
  logic                          out_playing_r, out_playing_nxt;

  logic                          div_start;
  logic [pcs_pkg::DIV_W-1:0]     div_dvd_ld;
  logic [pcs_pkg::SR_W-1:0]      div_dsr_ld;
  logic                          div_step;
  logic [pcs_pkg::SR_W:0]        div_trial;
  logic [pcs_pkg::SR_W:0]        div_diff;
  logic                          div_ge;
  logic [pcs_pkg::PROD_W-1:0]    ph_prod;
  logic [pcs_pkg::SEG_PROD_W-1:0] seg_prod;
  logic [pcs_pkg::SEG_W-1:0]     seg_quot;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.left_out   = out_left_r;
  assign out_ch.right_out  = out_right_r;
  assign out_ch.byte_taken = out_taken_r;
  assign out_ch.sound_done = out_done_r;
  assign out_ch.playing    = out_playing_r;

  assign ph_prod   = phase_r * tone_r;
  assign seg_prod  = sr_r[pcs_pkg::SR_W-1:pcs_pkg::SEG_PRE_SH] * pcs_pkg::SEG_RECIP;
  assign seg_quot  = seg_prod[pcs_pkg::SEG_SHIFT +: pcs_pkg::SEG_W];
  assign div_trial = {div_rem_r, div_dvd_r[pcs_pkg::DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, div_dsr_r});
  assign div_diff  = div_trial - {1'b0, div_dsr_r};

  always_comb begin
    state_nxt       = state_r;
    sr_nxt          = sr_r;
    active_nxt      = active_r;
    bytes_left_nxt  = bytes_left_r;
    prev_byte_nxt   = prev_byte_r;
    tone_nxt        = tone_r;
    seg_left_nxt    = seg_left_r;
    phase_nxt       = phase_r;
    div_rem_nxt     = div_rem_r;
    div_dvd_nxt     = div_dvd_r;
    div_dsr_nxt     = div_dsr_r;
    div_cnt_nxt     = div_cnt_r;
    sb_nxt          = sb_r;
    left_nxt        = left_r;
    right_nxt       = right_r;
    add_nxt         = add_r;
    taken_nxt       = taken_r;
    done_nxt        = done_r;
    out_valid_nxt   = out_valid_r;
    out_left_nxt    = out_left_r;
    out_right_nxt   = out_right_r;
    out_taken_nxt   = out_taken_r;
    out_done_nxt    = out_done_r;
    out_playing_nxt = out_playing_r;
    div_start       = 1'b0;
    div_dvd_ld      = '0;
    div_dsr_ld      = '0;
    div_step        = 1'b0;

    if (cfg_ch.valid) begin
      sr_nxt = cfg_ch.data;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sb_nxt    = in_ch.sound_byte;
          left_nxt  = in_ch.left_in;
          right_nxt = in_ch.right_in;
          add_nxt   = '0;
          taken_nxt = 1'b0;
          done_nxt  = 1'b0;
          state_nxt = S_OUT;
          case (in_ch.command)
            pcs_pkg::CMD_START: begin
              active_nxt     = 1'b1;
              bytes_left_nxt = in_ch.start_length;
              prev_byte_nxt  = pcs_pkg::BYTE_FRESH;
            end
            pcs_pkg::CMD_STOP: begin
              active_nxt = 1'b0;
            end
            pcs_pkg::CMD_TICK: begin
              state_nxt = S_PHASE;
              if (seg_left_r == '0) begin
                phase_nxt = '0;
                if (active_r) begin
                  state_nxt = S_SEG_END;
                end else begin
                  tone_nxt     = '0;
                  seg_left_nxt = pcs_pkg::SEG_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEG_END: begin
        seg_left_nxt   = (seg_quot == '0) ? pcs_pkg::SEG_W'(1) : seg_quot;
        taken_nxt      = 1'b1;
        bytes_left_nxt = bytes_left_r - pcs_pkg::LEN_W'(1);
        if (bytes_left_r == pcs_pkg::LEN_W'(1)) begin
          active_nxt = 1'b0;
          done_nxt   = 1'b1;
        end
        state_nxt = S_PHASE;
        if (sb_r != prev_byte_r) begin
          prev_byte_nxt = sb_r;
          if (sb_r != '0) begin
            div_start  = 1'b1;
            div_dvd_ld = pcs_pkg::DIV_W'(pcs_pkg::PIT_CLOCK);
            div_dsr_ld = pcs_pkg::SR_W'(sb_r) * pcs_pkg::SR_W'(pcs_pkg::RELOAD_SCALE);
            state_nxt  = S_TONE_DIV;
          end else begin
            tone_nxt = '0;
          end
        end
      end
      S_TONE_DIV: begin
        div_step = 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = S_TONE_END;
        end
      end
      S_TONE_END: begin
        tone_nxt  = div_dvd_r[pcs_pkg::TONE_W-1:0];
        state_nxt = S_PHASE;
      end
      S_PHASE: begin
        priority if (tone_r == '0) begin
          add_nxt      = '0;
          seg_left_nxt = seg_left_r - pcs_pkg::SEG_W'(1);
          state_nxt    = S_OUT;
        end else if (sr_r == '0) begin
          add_nxt      = pcs_pkg::SQUARE_POS;
          phase_nxt    = phase_r + pcs_pkg::PH_W'(1);
          seg_left_nxt = seg_left_r - pcs_pkg::SEG_W'(1);
          state_nxt    = S_OUT;
        end else begin
          div_start  = 1'b1;
          div_dvd_ld = {ph_prod, 1'b0};
          div_dsr_ld = sr_r;
          state_nxt  = S_PH_DIV;
        end
      end
      S_PH_DIV: begin
        div_step = 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = S_PH_END;
        end
      end
      S_PH_END: begin
        add_nxt      = div_dvd_r[0] ? pcs_pkg::SQUARE_NEG : pcs_pkg::SQUARE_POS;
        phase_nxt    = phase_r + pcs_pkg::PH_W'(1);
        seg_left_nxt = seg_left_r - pcs_pkg::SEG_W'(1);
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_left_nxt    = left_r + add_r;
          out_right_nxt   = right_r + add_r;
          out_taken_nxt   = taken_r;
          out_done_nxt    = done_r;
          out_playing_nxt = active_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (div_start) begin
      div_rem_nxt = '0;
      div_dvd_nxt = div_dvd_ld;
      div_dsr_nxt = div_dsr_ld;
      div_cnt_nxt = pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_W - 1);
    end else if (div_step) begin
      div_rem_nxt = div_ge ? div_diff[pcs_pkg::SR_W-1:0] : div_trial[pcs_pkg::SR_W-1:0];
      div_dvd_nxt = {div_dvd_r[pcs_pkg::DIV_W-2:0], div_ge};
      div_cnt_nxt = div_cnt_r - pcs_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sr_r         <= pcs_pkg::SR_RESET;
      active_r     <= 1'b0;
      bytes_left_r <= '0;
      prev_byte_r  <= '0;
      tone_r       <= '0;
      seg_left_r   <= '0;
      phase_r      <= '0;
      div_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sr_r         <= sr_nxt;
      active_r     <= active_nxt;
      bytes_left_r <= bytes_left_nxt;
      prev_byte_r  <= prev_byte_nxt;
      tone_r       <= tone_nxt;
      seg_left_r   <= seg_left_nxt;
      phase_r      <= phase_nxt;
      div_cnt_r    <= div_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_rem_r     <= div_rem_nxt;
    div_dvd_r     <= div_dvd_nxt;
    div_dsr_r     <= div_dsr_nxt;
    sb_r          <= sb_nxt;
    left_r        <= left_nxt;
    right_r       <= right_nxt;
    add_r         <= add_nxt;
    taken_r       <= taken_nxt;
    done_r        <= done_nxt;
    out_left_r    <= out_left_nxt;
    out_right_r   <= out_right_nxt;
    out_taken_r   <= out_taken_nxt;
    out_done_r    <= out_done_nxt;
    out_playing_r <= out_playing_nxt;
  end

`ifndef SYNTHESIS
  a_done_ends_sound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_taken_r && !out_playing_r))
    else $error("sound_done without byte_taken or with playing");

  a_taken_keeps_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_taken_r && !out_done_r) |-> out_playing_r)
    else $error("byte taken mid-sound but source dropped");

  a_start_attaches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.command == pcs_pkg::CMD_START)) |=> active_r)
    else $error("start command did not attach a source");
`endif

endmodule

/* sim/tb_pc_speaker_square_wave_synth.sv */
`timescale 1ns / 1ps

module tb_pc_speaker_square_wave_synth;
  import pcs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RATE_PICK      = -1;
  localparam int MAX_PRINTS     = 50;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_t;

  typedef struct {
    logic        [CMD_W-1:0]  command;
    logic        [LEN_W-1:0]  start_length;
    logic        [BYTE_W-1:0] sound_byte;
    logic signed [SMP_W-1:0]  left_in;
    logic signed [SMP_W-1:0]  right_in;
  } tone_item_t;

  typedef struct {
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
    logic                    byte_taken;
    logic                    sound_done;
    logic                    playing;
  } mix_result_t;

  typedef struct {
    bit              is_rate;
    logic [SR_W-1:0] rate;
    tone_item_t      item;
    bit              typed;
    mix_result_t     want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pcs_cfg_if cfg_ch();
  pcs_in_if  in_ch();
  pcs_out_if out_ch();

  pc_speaker_square_wave_synth dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  logic [SR_W-1:0]   rate_hz     = SR_RESET;
  logic              sounding    = 1'b0;
  logic [LEN_W-1:0]  bytes_to_go = '0;
  logic [BYTE_W-1:0] held_byte   = '0;
  logic [TONE_W-1:0] tone_hz     = '0;
  logic [SEG_W-1:0]  seg_count   = '0;
  logic [PH_W-1:0]   phase_idx   = '0;

  logic [BYTE_W-1:0] src_byte = '0;
  mix_result_t       mix_expected_q[$];
  int                mismatches  = 0;
  int                hold_asks   = 0;
  int                burst_left  = 0;
  int                idle_cycles = 0;

  int plan_rate [16] = '{139, 700, 8000, 140, 1400, 0, RATE_PICK, 280, RATE_PICK, 4200,
                         RATE_PICK, 2800, 131071, 96000, 44100, 0};
  int plan_items[16] = '{85, 85, 85, 85, 85, 85, 85, 85, 85, 85, 85, 85, 30, 30, 20, 20};

  function automatic mix_result_t predict_mix(input tone_item_t it);
    mix_result_t     res;
    logic [15:0]     add;
    logic [SR_W-1:0] seg;
    logic [31:0]     quot;
    add = '0;
    res.byte_taken = 1'b0;
    res.sound_done = 1'b0;
    case (it.command)
      CMD_START: begin
        sounding    = 1'b1;
        bytes_to_go = it.start_length;
        held_byte   = BYTE_FRESH;
      end
      CMD_STOP: sounding = 1'b0;
      CMD_TICK: begin
        if (seg_count == 0) begin
          phase_idx = '0;
          if (sounding) begin
            seg = rate_hz / SR_W'(SEG_RATE);
            if (seg == 0) seg = 1;
            seg_count = seg[SEG_W-1:0];
            if (it.sound_byte != held_byte) begin
              held_byte = it.sound_byte;
              quot = (it.sound_byte == 0) ? 32'd0 :
                     32'(PIT_CLOCK) / (32'(it.sound_byte) * 32'(RELOAD_SCALE));
              tone_hz = quot[TONE_W-1:0];
            end
            res.byte_taken = 1'b1;
            bytes_to_go = bytes_to_go - 1'b1;
            if (bytes_to_go == 0) begin
              sounding = 1'b0;
              res.sound_done = 1'b1;
            end
          end else begin
            tone_hz   = '0;
            seg_count = 1;
          end
        end
        if (tone_hz != 0) begin
          quot = (rate_hz == 0) ? 32'd0 :
                 (32'(phase_idx) * 32'(tone_hz) * 32'd2) / 32'(rate_hz);
          add = quot[0] ? SQUARE_NEG : SQUARE_POS;
          phase_idx = phase_idx + 1'b1;
        end
        seg_count = seg_count - 1'b1;
      end
      default: ;
    endcase
    res.left_out  = it.left_in + add;
    res.right_out = it.right_in + add;
    res.playing   = sounding;
    return res;
  endfunction

  function automatic step_row_t item_row(input logic [CMD_W-1:0] cmd, input int len,
                                         input int sb, input int l, input int r);
    step_row_t row;
    row.is_rate           = 1'b0;
    row.typed             = 1'b0;
    row.rate              = '0;
    row.item.command      = cmd;
    row.item.start_length = LEN_W'(len);
    row.item.sound_byte   = BYTE_W'(sb);
    row.item.left_in      = SMP_W'(l);
    row.item.right_in     = SMP_W'(r);
    return row;
  endfunction

  function automatic step_row_t typed_row(input logic [CMD_W-1:0] cmd, input int len,
                                          input int sb, input int l, input int r,
                                          input int lo, input int ro, input bit tk,
                                          input bit dn, input bit pl);
    step_row_t row;
    row = item_row(cmd, len, sb, l, r);
    row.typed           = 1'b1;
    row.want.left_out   = SMP_W'(lo);
    row.want.right_out  = SMP_W'(ro);
    row.want.byte_taken = tk;
    row.want.sound_done = dn;
    row.want.playing    = pl;
    return row;
  endfunction

  function automatic step_row_t rate_row(input int v);
    step_row_t row;
    row = item_row(CMD_TICK, 0, 0, 0, 0);
    row.is_rate = 1'b1;
    row.rate    = SR_W'(v);
    return row;
  endfunction

  function automatic tone_item_t next_random_item();
    tone_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.command      = CMD_TICK;
    it.start_length = LEN_W'($urandom);
    it.left_in      = SMP_W'($urandom);
    it.right_in     = SMP_W'($urandom);
    if ($urandom_range(0, 19) == 0) begin
      it.left_in  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      it.right_in = ~it.left_in;
    end
    if (!sounding && pick < 20) begin
      it.command = CMD_START;
      case ($urandom_range(0, 11))
        0:       ;
        1:       it.start_length = '0;
        2:       it.start_length = '1;
        default: it.start_length = LEN_W'($urandom_range(1, 4));
      endcase
    end else if (pick >= 96 && pick < 98) begin
      it.command = CMD_STOP;
    end else if (pick == 98) begin
      it.command = CMD_RSVD;
    end else if (pick == 99) begin
      it.command      = CMD_START;
      it.start_length = LEN_W'($urandom_range(1, 4));
    end else if (seg_count == 0 && sounding) begin
      case ($urandom_range(0, 9))
        0:       ;
        1:       src_byte = '0;
        2:       src_byte = '1;
        3:       src_byte = 8'd1;
        4:       src_byte = held_byte;
        default: src_byte = BYTE_W'($urandom_range(0, 255));
      endcase
    end else if ($urandom_range(0, 19) == 0) begin
      src_byte = BYTE_W'($urandom_range(0, 255));
    end
    it.sound_byte = src_byte;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
  endtask

  task automatic wait_drained();
    while (mix_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input step_row_t row);
    mix_result_t pred;
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.command      <= row.item.command;
    in_ch.start_length <= row.item.start_length;
    in_ch.sound_byte   <= row.item.sound_byte;
    in_ch.left_in      <= row.item.left_in;
    in_ch.right_in     <= row.item.right_in;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_mix(row.item);
    mix_expected_q.push_back(row.typed ? row.want : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_rate(input logic [SR_W-1:0] v);
    in_ch.valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    rate_hz = v;
  endtask

  always @(posedge clk) begin
    mix_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mix_expected_q.size() == 0) begin
        report_mismatch("unexpected item", out_ch.left_out, '0);
      end else begin
        want = mix_expected_q.pop_front();
        if (out_ch.left_out !== want.left_out)
          report_mismatch("left_out", out_ch.left_out, want.left_out);
        if (out_ch.right_out !== want.right_out)
          report_mismatch("right_out", out_ch.right_out, want.right_out);
        if (out_ch.byte_taken !== want.byte_taken)
          report_mismatch("byte_taken", 16'(out_ch.byte_taken), 16'(want.byte_taken));
        if (out_ch.sound_done !== want.sound_done)
          report_mismatch("sound_done", 16'(out_ch.sound_done), 16'(want.sound_done));
        if (out_ch.playing !== want.playing)
          report_mismatch("playing", 16'(out_ch.playing), 16'(want.playing));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int       hold_left;
    int       hold_served;
    int       mode_left;
    rx_mode_t mode;
    hold_left   = 0;
    hold_served = 0;
    mode_left   = 0;
    mode        = RX_FREE;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_served != hold_asks) begin
        hold_served++;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 120);
        end else begin
          mode_left--;
        end
        case (mode)
          RX_FREE: out_ch.ready <= 1'b1;
          RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    step_row_t steps[$];
    step_row_t row;
    int        rate;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_TICK;
    in_ch.start_length <= '0;
    in_ch.sound_byte   <= '0;
    in_ch.left_in      <= '0;
    in_ch.right_in     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;

    steps.push_back(typed_row(CMD_TICK, 0, 0, 'h7FFF, 'h8000, 'h7FFF, 'h8000, 0, 0, 0));
    steps.push_back(typed_row(CMD_RSVD, 9, 3, 'hFFFF, 0, 'hFFFF, 0, 0, 0, 0));
    steps.push_back(typed_row(CMD_STOP, 0, 0, 'h0123, 'h4567, 'h0123, 'h4567, 0, 0, 0));
    steps.push_back(rate_row(0));
    steps.push_back(typed_row(CMD_START, 3, 0, 'h1234, 'h8765, 'h1234, 'h8765, 0, 0, 1));
    steps.push_back(typed_row(CMD_TICK, 0, 1, 'h7FFF, 'h8000, 'h9FFF, 'hA000, 1, 0, 1));
    steps.push_back(item_row(CMD_TICK, 0, 1, 0, 'hFFFF));
    steps.push_back(typed_row(CMD_TICK, 0, 0, 'h1234, 'hFEDC, 'h1234, 'hFEDC, 1, 1, 0));
    steps.push_back(item_row(CMD_TICK, 0, 0, 'h5555, 'hAAAA));
    steps.push_back(rate_row(139));
    steps.push_back(typed_row(CMD_START, 0, 0, 'h8000, 'h7FFF, 'h8000, 'h7FFF, 0, 0, 1));
    steps.push_back(item_row(CMD_TICK, 0, 8, 'h8000, 'h7FFF));
    steps.push_back(item_row(CMD_TICK, 0, 200, 'h7FFF, 'h8000));
    steps.push_back(typed_row(CMD_START, 1, 0, 'h0F0F, 'hF0F0, 'h0F0F, 'hF0F0, 0, 0, 1));
    steps.push_back(item_row(CMD_TICK, 0, 255, 'hE000, 'h2000));
    steps.push_back(item_row(CMD_TICK, 0, 255, 'h1FFF, 'hDFFF));
    steps.push_back(rate_row(8000));
    steps.push_back(typed_row(CMD_START, 2, 0, 'h0001, 'hFFFE, 'h0001, 'hFFFE, 0, 0, 1));
    steps.push_back(item_row(CMD_TICK, 0, 64, 'h6000, 'hA000));
    steps.push_back(typed_row(CMD_STOP, 0, 64, 'h3333, 'hCCCC, 'h3333, 'hCCCC, 0, 0, 0));
    steps.push_back(item_row(CMD_TICK, 0, 64, 'h7000, 'h9000));
    steps.push_back(typed_row(CMD_RSVD, 5, 64, 'h2222, 'hDDDD, 'h2222, 'hDDDD, 0, 0, 0));
    steps.push_back(item_row(CMD_TICK, 0, 64, 'h4000, 'hC000));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].is_rate)
        write_rate(steps[i].rate);
      else
        send_item(steps[i]);
    end

    row = item_row(CMD_TICK, 0, 0, 0, 0);
    foreach (plan_rate[ph]) begin
      rate = (plan_rate[ph] == RATE_PICK) ? $urandom_range(0, 3000) : plan_rate[ph];
      write_rate(SR_W'(rate));
      if (ph == 2) hold_asks <= hold_asks + 1;
      for (int n = 0; n < plan_items[ph]; n++) begin
        if (ph == 4 && n == plan_items[ph] / 2) begin
          in_ch.valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        row.item = next_random_item();
        send_item(row);
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && mix_expected_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
